// ===== rtl/esd_pkg.sv =====
// Package for the elevator scan dispatcher: sizes, codes and the
// controller-to-datapath command and status types. No dependencies.
package esd_pkg;

    localparam int CARS = 3;
    localparam int FLOORS = 16;
    localparam int CAR_W = 2;
    localparam int FLOOR_W = 4;
    localparam int MAX_OUT = 9;
    localparam int CNT_W = 4;

    typedef logic [1:0] dir_t;
    localparam dir_t DIR_IDLE = 2'd0;
    localparam dir_t DIR_UP = 2'd1;
    localparam dir_t DIR_DOWN = 2'd2;

    typedef logic [1:0] kind_t;
    localparam kind_t KIND_TICK = 2'd0;
    localparam kind_t KIND_UP = 2'd1;
    localparam kind_t KIND_DOWN = 2'd2;
    localparam kind_t KIND_BUTTON = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UP_CALLS,
        ST_DOWN_CALLS,
        ST_MOVE,
        ST_OUT
    } state_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_LOAD,
        OP_EXEC,
        OP_UP_STEP,
        OP_DOWN_STEP,
        OP_MOVE_STEP
    } op_t;

    typedef struct packed {
        op_t op;
        logic [CAR_W-1:0] car;
        logic out_pop;
    } cmd_t;

    typedef struct packed {
        kind_t kind;
        logic up_pending;
        logic down_pending;
        logic up_take;
        logic down_take;
        logic out_empty;
    } status_t;

    function automatic logic [FLOOR_W-1:0] lowest(input logic [FLOORS-1:0] m);
        logic [FLOOR_W-1:0] r;
        r = '0;
        for (int i = FLOORS - 1; i >= 0; i--) begin
            if (m[i]) begin
                r = FLOOR_W'(i);
            end
        end
        return r;
    endfunction

    function automatic logic [FLOOR_W-1:0] highest(input logic [FLOORS-1:0] m);
        logic [FLOOR_W-1:0] r;
        r = '0;
        for (int i = 0; i < FLOORS; i++) begin
            if (m[i]) begin
                r = FLOOR_W'(i);
            end
        end
        return r;
    endfunction

    function automatic logic is_idle(input dir_t d);
        return (d != DIR_UP) && (d != DIR_DOWN);
    endfunction

    function automatic dir_t heading(input logic [FLOORS-1:0] s,
                                     input logic [FLOOR_W-1:0] here,
                                     input dir_t d);
        dir_t r;
        r = d;
        if (s == '0) begin
            r = DIR_IDLE;
        end
        else if ((d == DIR_UP || is_idle(d)) && highest(s) < here) begin
            r = DIR_DOWN;
        end
        else if ((d == DIR_DOWN || is_idle(d)) && lowest(s) > here) begin
            r = DIR_UP;
        end
        return r;
    endfunction

endpackage

// ===== rtl/elevator_scan_dispatcher.sv =====
// Top level of the elevator scan dispatcher: joins controller and datapath.
// Depends on esd_pkg, esd_ctrl and esd_datapath.
//
//   channel  direction  handshake           payload
//   input    in         in_valid/in_stall   kind, floor, car
//   output   out        out_valid/out_stall car_res, stop_floor, last
//
// A call or button item is loaded on acceptance, then executed, then its
// results are delivered before the next acceptance.
// A tick is loaded, then hands out up calls and then down calls in allotment
// passes over the cars, moves each car once, then delivers its results.
// Reset clears all cars to floor 0, idle, with no stops or calls.
// Output stall holds the current result; input stays stalled until the
// last result of the item has been taken.
module elevator_scan_dispatcher (
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_stall,
    input  logic [1:0] kind,
    input  logic [3:0] floor,
    input  logic [1:0] car,
    output logic out_valid,
    input  logic out_stall,
    output logic [1:0] car_res,
    output logic [3:0] stop_floor,
    output logic last
);
    import esd_pkg::*;

    cmd_t cmd;
    status_t status;

    esd_ctrl u_ctrl (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .status(status),
        .cmd(cmd)
    );

    esd_datapath u_dp (
        .clk(clk),
        .rst_n(rst_n),
        .cmd(cmd),
        .status(status),
        .kind(kind),
        .floor(floor),
        .car(car),
        .car_res(car_res),
        .stop_floor(stop_floor),
        .last(last)
    );

endmodule

// ===== rtl/esd_datapath.sv =====
// Datapath of the elevator scan dispatcher: call bitmaps, car state and
// the result queue. Depends on esd_pkg.
module esd_datapath (
    input  logic clk,
    input  logic rst_n,
    input  esd_pkg::cmd_t cmd,
    output esd_pkg::status_t status,
    input  logic [1:0] kind,
    input  logic [3:0] floor,
    input  logic [1:0] car,
    output logic [1:0] car_res,
    output logic [3:0] stop_floor,
    output logic last
);
    import esd_pkg::*;

    logic [FLOOR_W-1:0] floor_reg [CARS];
    dir_t dir_reg [CARS];
    logic [FLOORS-1:0] stops_reg [CARS];
    logic [FLOORS-1:0] up_reg;
    logic [FLOORS-1:0] down_reg;
    kind_t kind_reg;
    logic [FLOOR_W-1:0] fl_reg;
    logic [CAR_W-1:0] car_reg;
    logic [CAR_W-1:0] qc_reg [MAX_OUT];
    logic [FLOOR_W-1:0] qf_reg [MAX_OUT];
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] rd_reg;

    logic [FLOOR_W-1:0] cf;
    dir_t cd;
    logic [FLOORS-1:0] cs;
    logic [FLOOR_W-1:0] up_lo;
    logic [FLOOR_W-1:0] dn_hi;
    logic [FLOOR_W-1:0] mv;

    assign cf = floor_reg[cmd.car];
    assign cd = dir_reg[cmd.car];
    assign cs = stops_reg[cmd.car];
    assign up_lo = lowest(up_reg);
    assign dn_hi = highest(down_reg);

    always_comb
    begin
        mv = cf;
        if (cd == DIR_UP && cf != FLOOR_W'(FLOORS - 1)) begin
            mv = cf + 1'b1;
        end
        else if (cd == DIR_DOWN && cf != '0) begin
            mv = cf - 1'b1;
        end
    end

    assign status.kind = kind_reg;
    assign status.up_pending = (up_reg != '0);
    assign status.down_pending = (down_reg != '0);
    assign status.up_take = (up_reg != '0) && ((cd == DIR_UP && cf < up_lo) || is_idle(cd));
    assign status.down_take = (down_reg != '0) &&
                              ((cd == DIR_DOWN && cf > dn_hi) || is_idle(cd));
    assign status.out_empty = (rd_reg == cnt_reg);

    assign car_res = qc_reg[rd_reg];
    assign stop_floor = qf_reg[rd_reg];
    assign last = (rd_reg + 1'b1 == cnt_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_LOAD) begin
            kind_reg <= kind;
            fl_reg <= floor;
            car_reg <= car;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            for (int i = 0; i < CARS; i++) begin
                floor_reg[i] <= '0;
                dir_reg[i] <= DIR_IDLE;
                stops_reg[i] <= '0;
            end
            up_reg <= '0;
            down_reg <= '0;
            cnt_reg <= '0;
            rd_reg <= '0;
        end
        else begin
            if (cmd.out_pop) begin
                rd_reg <= rd_reg + 1'b1;
            end
            case (cmd.op)
                OP_LOAD:
                begin
                    cnt_reg <= '0;
                    rd_reg <= '0;
                end
                OP_EXEC:
                begin
                    case (kind_reg)
                        KIND_UP: up_reg[fl_reg] <= 1'b1;
                        KIND_DOWN: down_reg[fl_reg] <= 1'b1;
                        KIND_BUTTON:
                        begin
                            if (32'(car_reg) < CARS) begin
                                if (floor_reg[car_reg] == fl_reg) begin
                                    qc_reg[0] <= car_reg;
                                    qf_reg[0] <= fl_reg;
                                    cnt_reg <= CNT_W'(1);
                                end
                                else begin
                                    stops_reg[car_reg][fl_reg] <= 1'b1;
                                    dir_reg[car_reg] <= heading(
                                        stops_reg[car_reg] | (FLOORS'(1) << fl_reg),
                                        floor_reg[car_reg], dir_reg[car_reg]);
                                end
                            end
                        end
                        default: ;
                    endcase
                end
                OP_UP_STEP, OP_DOWN_STEP:
                begin
                    if (cmd.op == OP_UP_STEP) begin
                        up_reg[up_lo] <= 1'b0;
                    end
                    else begin
                        down_reg[dn_hi] <= 1'b0;
                    end
                    if (cf == ((cmd.op == OP_UP_STEP) ? up_lo : dn_hi)) begin
                        if (cnt_reg < CNT_W'(MAX_OUT)) begin
                            qc_reg[cnt_reg] <= cmd.car;
                            qf_reg[cnt_reg] <= cf;
                            cnt_reg <= cnt_reg + 1'b1;
                        end
                    end
                    else begin
                        stops_reg[cmd.car] <= cs | (FLOORS'(1) <<
                            ((cmd.op == OP_UP_STEP) ? up_lo : dn_hi));
                        dir_reg[cmd.car] <= heading(cs | (FLOORS'(1) <<
                            ((cmd.op == OP_UP_STEP) ? up_lo : dn_hi)), cf, cd);
                    end
                end
                OP_MOVE_STEP:
                begin
                    floor_reg[cmd.car] <= mv;
                    if (cs[mv]) begin
                        if (cnt_reg < CNT_W'(MAX_OUT)) begin
                            qc_reg[cnt_reg] <= cmd.car;
                            qf_reg[cnt_reg] <= mv;
                            cnt_reg <= cnt_reg + 1'b1;
                        end
                        stops_reg[cmd.car][mv] <= 1'b0;
                        dir_reg[cmd.car] <= heading(cs & ~(FLOORS'(1) << mv), mv, cd);
                    end
                end
                default: ;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(MAX_OUT)) else $error("queue count overflow");
    a_rd_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rd_reg <= cnt_reg) else $error("queue read past count");
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_pop |-> !status.out_empty) else $error("pop from empty queue");
`endif

endmodule

// ===== rtl/esd_ctrl.sv =====
// Controller of the elevator scan dispatcher: sequences item loading and execution, call
// allotment, car moves and result delivery. Depends on esd_pkg.
module esd_ctrl (
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_stall,
    output logic out_valid,
    input  logic out_stall,
    input  esd_pkg::status_t status,
    output esd_pkg::cmd_t cmd
);
    import esd_pkg::*;

    state_t state_reg, state_next;
    logic [CAR_W-1:0] car_reg, car_next;
    logic exec_reg, exec_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= ST_IDLE;
            car_reg <= '0;
            exec_reg <= 1'b0;
        end
        else begin
            state_reg <= state_next;
            car_reg <= car_next;
            exec_reg <= exec_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        car_next = car_reg;
        exec_next = 1'b0;
        cmd = '{op: OP_NONE, car: car_reg, out_pop: 1'b0};
        in_stall = 1'b1;
        out_valid = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid) begin
                    cmd.op = OP_LOAD;
                    exec_next = 1'b1;
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (exec_reg) begin
                    car_next = '0;
                    if (status.kind != KIND_TICK) begin
                        cmd.op = OP_EXEC;
                    end
                    else if (status.up_pending) begin
                        state_next = ST_UP_CALLS;
                    end
                    else if (status.down_pending) begin
                        state_next = ST_DOWN_CALLS;
                    end
                    else begin
                        state_next = ST_MOVE;
                    end
                end
                else if (status.out_empty) begin
                    state_next = ST_IDLE;
                end
                else begin
                    out_valid = 1'b1;
                    cmd.out_pop = !out_stall;
                end
            end
            ST_UP_CALLS:
            begin
                if (!status.up_pending) begin
                    car_next = '0;
                    state_next = status.down_pending ? ST_DOWN_CALLS : ST_MOVE;
                end
                else if (status.up_take) begin
                    cmd.op = OP_UP_STEP;
                end
                else if (32'(car_reg) == CARS - 1) begin
                    car_next = '0;
                    state_next = status.down_pending ? ST_DOWN_CALLS : ST_MOVE;
                end
                else begin
                    car_next = car_reg + 1'b1;
                end
            end
            ST_DOWN_CALLS:
            begin
                if (!status.down_pending) begin
                    car_next = '0;
                    state_next = ST_MOVE;
                end
                else if (status.down_take) begin
                    cmd.op = OP_DOWN_STEP;
                end
                else if (32'(car_reg) == CARS - 1) begin
                    car_next = '0;
                    state_next = ST_MOVE;
                end
                else begin
                    car_next = car_reg + 1'b1;
                end
            end
            ST_MOVE:
            begin
                cmd.op = OP_MOVE_STEP;
                if (32'(car_reg) == CARS - 1) begin
                    state_next = ST_OUT;
                end
                else begin
                    car_next = car_reg + 1'b1;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

`ifndef SYNTHESIS
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> in_stall) else $error("input taken while busy");
    a_exec_follows_load: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_LOAD) |=> (state_reg == ST_OUT && exec_reg))
        else $error("load not followed by execute");
    a_out_only_deliver: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (state_reg == ST_OUT && !exec_reg))
        else $error("result shown outside delivery");
`endif

endmodule
